// ===== hdl/sts_pkg.sv =====
// ----------------------------------------------------------------------------
// sts_pkg
// Shared codes for the signal tree select/set block.
// ----------------------------------------------------------------------------
package sts_pkg;

  // request operation codes
  localparam logic OP_SET    = 1'b0;
  localparam logic OP_SELECT = 1'b1;

endpackage

// ===== hdl/signal_tree_select_set.sv =====
// ----------------------------------------------------------------------------
// signal_tree_select_set
// Pending-signal bitmap with a heap-ordered tree of subtree counters.
// Set raises one flag and bumps the counters on its path to the root.
// Select walks down by bias bits, decrementing counters, and clears a flag.
// ----------------------------------------------------------------------------
// Sequence from accept to the done strobe: set reads the flag in S_SET_CHK
// (done there if already set), then S_SET_UP bumps one counter per level up
// to the root; select steps down the tree in S_SEL_NODE, then clears a flag
// in S_SEL_LEAF, or is done from idle when the tree is empty. One request at
// a time; busy stays high until done. The counter RAM does one
// read-modify-write per tree level. Results cannot be stalled. After rst, and
// after each cfg_wr_en write, a fill sweep loads the RAMs (empty, or full when cfg_wr_data is 1); busy is high.
module signal_tree_select_set
  import sts_pkg::*;
#(
  parameter int NUM_SIGNALS = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           operation,
  input  logic [$clog2(NUM_SIGNALS)-1:0] signal_index,
  input  logic [$clog2(NUM_SIGNALS)-1:0] bias_bits,
  input  logic                           cfg_wr_en,
  input  logic                           cfg_wr_data,
  output logic                           done,
  output logic                           ok,
  output logic [$clog2(NUM_SIGNALS)-1:0] selected_index,
  output logic [$clog2(NUM_SIGNALS):0]   total_count
);

  localparam int IDX_W      = $clog2(NUM_SIGNALS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int NODE_TOTAL = NUM_SIGNALS - 1;
  localparam int LVL_W      = $clog2(IDX_W + 1);

  localparam logic [LVL_W-1:0] LVL_LAST  = LVL_W'((IDX_W > 1) ? (IDX_W - 2) : 0);
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(NUM_SIGNALS - 1);
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(NUM_SIGNALS);
  localparam logic [IDX_W:0]   LEAF_BASE = (IDX_W + 1)'(NUM_SIGNALS - 2);

  typedef enum logic [2:0] {
    S_FILL,
    S_IDLE,
    S_SET_CHK,
    S_SET_UP,
    S_SEL_NODE,
    S_SEL_LEAF
  } state_t;

  state_t state;

  // counter and flag RAMs: one write port, two registered read ports
  logic [CNT_W-1:0] node_mem [NODE_TOTAL];
  logic             leaf_mem [NUM_SIGNALS];

  logic             node_we;
  logic [IDX_W-1:0] node_wa;
  logic [CNT_W-1:0] node_wd;
  logic [IDX_W-1:0] node_ra_a;
  logic [IDX_W-1:0] node_ra_b;
  logic [CNT_W-1:0] node_qa;
  logic [CNT_W-1:0] node_qb;
  logic             leaf_we;
  logic [IDX_W-1:0] leaf_wa;
  logic             leaf_wd;
  logic [IDX_W-1:0] leaf_ra_a;
  logic [IDX_W-1:0] leaf_ra_b;
  logic             leaf_qa;
  logic             leaf_qb;

  // walk registers
  logic [IDX_W-1:0] cur;
  logic [IDX_W-1:0] bias;
  logic [IDX_W-1:0] idx;
  logic [LVL_W-1:0] lvl;
  logic [CNT_W-1:0] total;

  // fill sweep
  logic             fill_full;
  logic [IDX_W-1:0] fill_idx;
  logic [CNT_W-1:0] fill_cnt;
  logic [IDX_W-1:0] lvl_end;

  // combinational walk decisions
  logic             swap;
  logic [IDX_W-1:0] cur_node_a;
  logic [IDX_W-1:0] cur_node_b;
  logic [IDX_W-1:0] cur_leaf_a;
  logic [IDX_W-1:0] cur_leaf_b;
  logic [CNT_W-1:0] first_cnt;
  logic [CNT_W-1:0] second_cnt;
  logic [IDX_W-1:0] first_addr;
  logic [IDX_W-1:0] second_addr;
  logic [IDX_W-1:0] pick_addr;
  logic [CNT_W-1:0] pick_wd;
  logic             first_flag;
  logic [IDX_W-1:0] first_leaf;
  logic [IDX_W-1:0] second_leaf;
  logic [IDX_W-1:0] pick_leaf;
  logic [IDX_W-1:0] sel_cur;
  logic [IDX_W:0]   leaf_node;
  logic [IDX_W-1:0] leaf_parent;
  logic [IDX_W-1:0] cur_dec;
  logic [IDX_W-1:0] cur_parent;
  logic             accept;

  assign busy        = (state != S_IDLE);
  assign accept      = start && !busy;
  assign total_count = total;

  always_comb begin
    swap        = bias[0];
    cur_node_a  = IDX_W'({cur, 1'b0} + (IDX_W + 1)'(1));
    cur_node_b  = IDX_W'({cur, 1'b0} + (IDX_W + 1)'(2));
    // leaf number of node n is n - (N-1); modulo N this is just the low bits
    cur_leaf_a  = IDX_W'({cur, 1'b0} + (IDX_W + 1)'(2));
    cur_leaf_b  = cur_leaf_a | IDX_W'(1);

    first_cnt   = swap ? node_qb : node_qa;
    second_cnt  = swap ? node_qa : node_qb;
    first_addr  = swap ? cur_node_b : cur_node_a;
    second_addr = swap ? cur_node_a : cur_node_b;
    if (first_cnt != '0) begin
      pick_addr = first_addr;
      pick_wd   = first_cnt - CNT_W'(1);
    end else begin
      pick_addr = second_addr;
      pick_wd   = (second_cnt != '0) ? (second_cnt - CNT_W'(1)) : second_cnt;
    end

    first_flag  = swap ? leaf_qb : leaf_qa;
    first_leaf  = swap ? cur_leaf_b : cur_leaf_a;
    second_leaf = swap ? cur_leaf_a : cur_leaf_b;
    pick_leaf   = first_flag ? first_leaf : second_leaf;

    leaf_node   = {1'b0, idx} + LEAF_BASE;
    leaf_parent = IDX_W'(leaf_node >> 1);
    cur_dec     = cur - IDX_W'(1);
    cur_parent  = cur_dec >> 1;

    // node whose children the select walk reads next
    sel_cur     = (state == S_SEL_NODE) ? pick_addr : '0;
  end

  // memory port control
  always_comb begin
    node_we   = 1'b0;
    node_wa   = '0;
    node_wd   = '0;
    leaf_we   = 1'b0;
    leaf_wa   = '0;
    leaf_wd   = 1'b0;
    node_ra_a = IDX_W'({sel_cur, 1'b0} + (IDX_W + 1)'(1));
    node_ra_b = IDX_W'({sel_cur, 1'b0} + (IDX_W + 1)'(2));
    leaf_ra_a = IDX_W'({sel_cur, 1'b0} + (IDX_W + 1)'(2));
    leaf_ra_b = leaf_ra_a | IDX_W'(1);
    case (state)
      S_FILL: begin
        leaf_we = 1'b1;
        leaf_wa = fill_idx;
        leaf_wd = fill_full;
        node_we = (fill_idx != IDX_LAST);
        node_wa = fill_idx;
        node_wd = fill_full ? fill_cnt : '0;
      end
      S_IDLE: begin
        if (operation == OP_SET) begin
          leaf_ra_a = signal_index;
        end else if (accept && total != '0) begin
          // root always mirrors total
          node_we = 1'b1;
          node_wa = '0;
          node_wd = total - CNT_W'(1);
        end
      end
      S_SET_CHK: begin
        node_ra_a = leaf_parent;
        if (!leaf_qa) begin
          leaf_we = 1'b1;
          leaf_wa = idx;
          leaf_wd = 1'b1;
        end
      end
      S_SET_UP: begin
        node_ra_a = cur_parent;
        node_we   = 1'b1;
        node_wa   = cur;
        node_wd   = node_qa + CNT_W'(1);
      end
      S_SEL_NODE: begin
        node_we = 1'b1;
        node_wa = pick_addr;
        node_wd = pick_wd;
      end
      S_SEL_LEAF: begin
        leaf_we = 1'b1;
        leaf_wa = pick_leaf;
        leaf_wd = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_wa] <= node_wd;
    end
    node_qa <= node_mem[node_ra_a];
    node_qb <= node_mem[node_ra_b];
    if (leaf_we) begin
      leaf_mem[leaf_wa] <= leaf_wd;
    end
    leaf_qa <= leaf_mem[leaf_ra_a];
    leaf_qb <= leaf_mem[leaf_ra_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_FILL;
      done      <= 1'b0;
      total     <= '0;
      fill_full <= 1'b0;
      fill_idx  <= '0;
      fill_cnt  <= CNT_FULL;
      lvl_end   <= '0;
    end else if (cfg_wr_en) begin
      state     <= S_FILL;
      done      <= 1'b0;
      fill_full <= cfg_wr_data;
      fill_idx  <= '0;
      fill_cnt  <= CNT_FULL;
      lvl_end   <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_FILL: begin
          fill_idx <= fill_idx + IDX_W'(1);
          // full count halves at the end of each tree level
          if (fill_idx == lvl_end) begin
            fill_cnt <= fill_cnt >> 1;
            lvl_end  <= IDX_W'({lvl_end, 1'b0} + (IDX_W + 1)'(2));
          end
          if (fill_idx == IDX_LAST) begin
            state <= S_IDLE;
            total <= fill_full ? CNT_FULL : '0;
          end
        end
        S_IDLE: begin
          if (start) begin
            if (operation == OP_SET) begin
              idx   <= signal_index;
              state <= S_SET_CHK;
            end else if (total == '0) begin
              done           <= 1'b1;
              ok             <= 1'b0;
              selected_index <= '0;
            end else begin
              total <= total - CNT_W'(1);
              cur   <= '0;
              lvl   <= '0;
              bias  <= bias_bits;
              state <= (IDX_W == 1) ? S_SEL_LEAF : S_SEL_NODE;
            end
          end
        end
        S_SET_CHK: begin
          if (leaf_qa) begin
            done           <= 1'b1;
            ok             <= 1'b0;
            selected_index <= '0;
            state          <= S_IDLE;
          end else begin
            cur   <= leaf_parent;
            state <= S_SET_UP;
          end
        end
        S_SET_UP: begin
          if (cur == '0) begin
            done           <= 1'b1;
            ok             <= 1'b1;
            selected_index <= '0;
            total          <= total + CNT_W'(1);
            state          <= S_IDLE;
          end else begin
            cur <= cur_parent;
          end
        end
        S_SEL_NODE: begin
          cur  <= pick_addr;
          bias <= bias >> 1;
          lvl  <= lvl + LVL_W'(1);
          if (lvl == LVL_LAST) begin
            state <= S_SEL_LEAF;
          end
        end
        S_SEL_LEAF: begin
          done           <= 1'b1;
          ok             <= 1'b1;
          selected_index <= pick_leaf;
          state          <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
